/* sv/positional_array_list_defines.svh */
// Assertion helpers shared by the list logic.
// Each macro needs clk and rst in the scope where it is used.
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define PAL_CHECK_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// Check a condition in the cycle after its trigger.
`define PAL_CHECK_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

/* sv/pal_pkg.sv */
package pal_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_DELETE   = 2'd1,
    ACT_LOCATE   = 2'd2,
    ACT_RETRIEVE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // What every cell does on the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

endpackage

/* sv/pal_cell.sv */
module pal_cell import pal_pkg::*; #(
  parameter int unsigned      IDX_W = 6,
  parameter logic [IDX_W-1:0] INDEX = '0
) (
  input  logic              clk,
  input  cell_op_t          op,
  input  logic [IDX_W-1:0]  slot,
  input  logic [IDX_W-1:0]  last,
  input  logic [DATA_W-1:0] ins_value,
  input  logic [DATA_W-1:0] left_value,
  input  logic [DATA_W-1:0] right_value,
  input  logic [DATA_W-1:0] head_value,
  output logic [DATA_W-1:0] value
);

  logic [DATA_W-1:0] value_next;

  always_comb begin
    value_next = value;
    unique case (op)
      CELL_HOLD: ;
      CELL_INSERT: begin
        // load at the slot, shift up above it
        if (INDEX == slot) begin
          value_next = ins_value;
        end else if (INDEX > slot) begin
          value_next = left_value;
        end
      end
      CELL_DELETE: begin
        // close the gap from above
        if (INDEX >= slot) begin
          value_next = right_value;
        end
      end
      CELL_ROTATE: begin
        // the last used cell wraps around to the head
        value_next = (INDEX == last) ? head_value : right_value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

/* sv/positional_array_list.sv */
// Channel   Direction  Handshake               Payload
// request   in         start high, busy low    action, slot, item_value
// result    out        done strobe, one cycle  read_value, found_slot, status, count_now
//
// Insert, delete and every rejected request finish at once: the result is on the
// ports in the cycle after acceptance, and busy stays low.
// Locate and retrieve spin the used part of the cell ring through cell 0, one
// entry per cycle: busy until the last step, result in the cycle after the last step.
// Reset clears the entry count and the control; the cells themselves are not cleared.
// The receiver cannot stall; a result shows for exactly one cycle.
`include "positional_array_list_defines.svh"

module positional_array_list import pal_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         action,
  input  logic [$clog2(CAPACITY+1)-1:0]      slot,
  input  logic signed [DATA_W-1:0]           item_value,
  output logic                               done,
  output logic signed [DATA_W-1:0]           read_value,
  output logic [$clog2(CAPACITY+1)-1:0]      found_slot,
  output logic [1:0]                         status,
  output logic [$clog2(CAPACITY+1)-1:0]      count_now
);

  // CW holds a count up to CAPACITY, SW walks positions 0 to CAPACITY-1.
  localparam int unsigned     CW    = $clog2(CAPACITY + 1);
  localparam int unsigned     SW    = $clog2(CAPACITY);
  localparam logic [CW-1:0]   CAP_C = CW'(CAPACITY);

  typedef enum logic {
    IDLE,
    SCAN
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [SW-1:0]     step;
  action_t           scan_act;
  logic [DATA_W-1:0] key;
  logic [CW-1:0]     scan_slot;
  logic              hit;
  logic [SW-1:0]     hit_idx;
  logic [DATA_W-1:0] rd_hold;

  logic [DATA_W-1:0] cells [CAPACITY];

  action_t           act;
  logic              accept;
  logic              ins_ok;
  logic              del_ok;
  logic [DATA_W-1:0] head;
  logic [CW-1:0]     last_idx;
  logic              last_step;
  logic              match_now;
  logic              slot_now;
  cell_op_t          cell_op;

  assign busy = (state == SCAN);

  always_comb begin
    act       = action_t'(action);
    accept    = start && !busy;
    ins_ok    = (count != CAP_C) && (slot <= count);
    del_ok    = slot < count;
    head      = cells[0];
    last_idx  = count - CW'(1);
    last_step = (CW'(step) == last_idx);
    // cell 0 holds entry number step during a scan
    match_now = (head == key);
    slot_now  = (CW'(step) == scan_slot);

    cell_op = CELL_HOLD;
    if (state == SCAN) begin
      cell_op = CELL_ROTATE;
    end else if (accept) begin
      unique case (act)
        ACT_INSERT: if (ins_ok) cell_op = CELL_INSERT;
        ACT_DELETE: if (del_ok) cell_op = CELL_DELETE;
        default: ;
      endcase
    end
  end

  // The chain: every cell sees its neighbors on both sides and the head.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_W-1:0] left_v;
    logic [DATA_W-1:0] right_v;

    if (k == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_inner_l
      assign left_v = cells[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_v = cells[k];
    end else begin : g_inner_r
      assign right_v = cells[k+1];
    end

    pal_cell #(
      .IDX_W (CW),
      .INDEX (CW'(k))
    ) u_cell (
      .clk         (clk),
      .op          (cell_op),
      .slot        (slot),
      .last        (last_idx),
      .ins_value   (item_value),
      .left_value  (left_v),
      .right_value (right_v),
      .head_value  (head),
      .value       (cells[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      done  <= 1'b0;
      hit   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            read_value <= '0;
            found_slot <= '0;
            count_now  <= count;
            status     <= ST_OK;
            unique case (act)
              ACT_INSERT: begin
                done <= 1'b1;
                // a full list wins over a bad position
                if (count == CAP_C) begin
                  status <= ST_FULL;
                end else if (!ins_ok) begin
                  status <= ST_BAD_POS;
                end else begin
                  count     <= count + CW'(1);
                  count_now <= count + CW'(1);
                end
              end
              ACT_DELETE: begin
                done <= 1'b1;
                if (!del_ok) begin
                  status <= ST_BAD_POS;
                end else begin
                  count     <= count - CW'(1);
                  count_now <= count - CW'(1);
                end
              end
              ACT_LOCATE: begin
                if (count == '0) begin
                  // nothing to search: report the count
                  done       <= 1'b1;
                  status     <= ST_NOT_FOUND;
                  found_slot <= count;
                end else begin
                  state    <= SCAN;
                  step     <= '0;
                  hit      <= 1'b0;
                  key      <= item_value;
                  scan_act <= act;
                end
              end
              ACT_RETRIEVE: begin
                if (!del_ok) begin
                  done   <= 1'b1;
                  status <= ST_BAD_POS;
                end else begin
                  state     <= SCAN;
                  step      <= '0;
                  hit       <= 1'b0;
                  scan_slot <= slot;
                  scan_act  <= act;
                end
              end
            endcase
          end
        end
        SCAN: begin
          step <= step + SW'(1);
          // keep only the first match
          if (!hit && match_now) begin
            hit     <= 1'b1;
            hit_idx <= step;
          end
          if (slot_now) begin
            rd_hold <= head;
          end
          if (last_step) begin
            // the ring is back in order after this rotation
            state      <= IDLE;
            done       <= 1'b1;
            count_now  <= count;
            read_value <= '0;
            found_slot <= '0;
            status     <= ST_OK;
            if (scan_act == ACT_LOCATE) begin
              if (hit) begin
                found_slot <= CW'(hit_idx);
              end else if (match_now) begin
                found_slot <= CW'(step);
              end else begin
                found_slot <= count;
                status     <= ST_NOT_FOUND;
              end
            end else begin
              read_value <= $signed(slot_now ? head : rd_hold);
            end
          end
        end
      endcase
    end
  end

  `PAL_CHECK_NOW(a_count_bound, 1'b1, count <= CAP_C, "entry count above capacity")
  `PAL_CHECK_NOW(a_result_count, done, count_now == count, "reported count disagrees with state")
  `PAL_CHECK_NEXT(a_scan_ends, (state == SCAN) && last_step, done && !busy, "scan did not end")
  `PAL_CHECK_NEXT(a_count_hold, !accept, $stable(count), "count changed without a transaction")

endmodule
